>>> sv/radix_text_to_integer_top_defines.svh
// Assertion macros shared by the radix text to integer RTL
`ifndef RADIX_TEXT_TO_INTEGER_TOP_DEFINES_SVH
`define RADIX_TEXT_TO_INTEGER_TOP_DEFINES_SVH

// expression holds at every clock edge outside reset
`define RTTI_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("rtti assertion failed");

// consequent holds in the cycle after the antecedent
`define RTTI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtti assertion failed");

`endif

>>> sv/rtti_pkg.sv
// Types, constants and helper functions of the radix text to integer block
package rtti_pkg;

  localparam int MaxSymbols = 16;
  localparam int SymW       = 8;
  localparam int IdxW       = $clog2(MaxSymbols);
  localparam int RadixW     = 5;
  localparam int AlphaW     = 128;
  localparam int ValueW     = 64;
  localparam int CfgW       = 64;
  localparam int CfgIdxW    = 2;
  localparam int QDepth     = 2;
  localparam int QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW      = $clog2(QDepth + 1);

  localparam logic [CfgW-1:0]   AlphaLowRst  = 64'd3978425819141910832;
  localparam logic [CfgW-1:0]   AlphaHighRst = 64'd14648;
  localparam logic [RadixW-1:0] SizeRst      = 5'd10;

  localparam logic [SymW-1:0] ChNul     = 8'd0;
  localparam logic [SymW-1:0] ChPlus    = 8'd43;
  localparam logic [SymW-1:0] ChMinus   = 8'd45;
  localparam logic [SymW-1:0] ChSpace   = 8'd32;
  localparam logic [SymW-1:0] ChWsFirst = 8'd9;
  localparam logic [SymW-1:0] ChWsLast  = 8'd13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA_LOW,
    CFG_ALPHA_HIGH,
    CFG_ALPHA_SIZE
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNS,
    PH_DIGITS
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_ALPHA,
    ST_FOREIGN
  } status_e;

  typedef struct packed {
    logic              start;
    logic              alpha_ok;
    logic              space;
    logic              minus;
    logic              plus;
    logic              hit;
    logic [IdxW-1:0]   idx;
    logic [RadixW-1:0] radix;
  } entry_t;

  function automatic logic alpha_ok(logic [AlphaW-1:0] alpha, logic [RadixW-1:0] size);
    logic            ok;
    logic [SymW-1:0] sa;
    ok = (size >= RadixW'(2)) && (size <= RadixW'(MaxSymbols));
    for (int a = 0; a < MaxSymbols; a++) begin
      sa = alpha[a*SymW +: SymW];
      if (RadixW'(a) < size) begin
        if (sa == ChPlus || sa == ChMinus || sa == ChNul) begin
          ok = 1'b0;
        end
        for (int b = a + 1; b < MaxSymbols; b++) begin
          if (RadixW'(b) < size && alpha[b*SymW +: SymW] == sa) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

>>> sv/rtti_front.sv
// Front end: configuration registers, alphabet check and character classification
module rtti_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rtti_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rtti_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rtti_pkg::SymW-1:0]      in_char_i,
  input  logic                           in_start_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output rtti_pkg::entry_t               entry_o
);
  import rtti_pkg::*;

  logic [CfgW-1:0]   alpha_low_q, alpha_high_q;
  logic [RadixW-1:0] size_q;
  logic [AlphaW-1:0] alpha;
  logic              hit;
  logic [IdxW-1:0]   idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_low_q  <= AlphaLowRst;
      alpha_high_q <= AlphaHighRst;
      size_q       <= SizeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA_LOW:  alpha_low_q  <= cfg_wdata_i;
        CFG_ALPHA_HIGH: alpha_high_q <= cfg_wdata_i;
        CFG_ALPHA_SIZE: size_q       <= cfg_wdata_i[RadixW-1:0];
        default: ;
      endcase
    end
  end

  assign alpha = {alpha_high_q, alpha_low_q};

  // lowest matching symbol wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int k = MaxSymbols - 1; k >= 0; k--) begin
      if (RadixW'(k) < size_q && alpha[k*SymW +: SymW] == in_char_i) begin
        hit = 1'b1;
        idx = IdxW'(k);
      end
    end
  end

  always_comb begin
    entry_o.start    = in_start_i;
    entry_o.alpha_ok = alpha_ok(alpha, size_q);
    entry_o.space    = (in_char_i inside {[ChWsFirst:ChWsLast], ChSpace});
    entry_o.minus    = (in_char_i == ChMinus);
    entry_o.plus     = (in_char_i == ChPlus);
    entry_o.hit      = hit;
    entry_o.idx      = idx;
    entry_o.radix    = size_q;
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

>>> sv/rtti_fifo.sv
// Short queue of classified characters between front and back end
module rtti_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rtti_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output rtti_pkg::entry_t head_o
);
  import rtti_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  `include "radix_text_to_integer_top_defines.svh"
  `RTTI_ASSERT(a_cnt_bound, count_q <= QCntW'(QDepth))
  `RTTI_ASSERT(a_no_pop_empty, !pop_i || count_q != '0)
  `RTTI_ASSERT(a_no_push_full, !push_i || count_q != QCntW'(QDepth))

endmodule

>>> sv/rtti_back.sv
// Back end: parse state, multiply-add accumulator and result register
module rtti_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  rtti_pkg::entry_t              head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rtti_pkg::ValueW-1:0]   out_value_o,
  output rtti_pkg::status_e             out_status_o
);
  import rtti_pkg::*;

  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q, res_value;
  status_e           out_status_q, res_status;
  logic              emit, done;

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    phase_d    = phase_q;
    neg_d      = neg_q;
    acc_d      = acc_q;
    emit       = 1'b0;
    done       = 1'b0;
    res_value  = '0;
    res_status = ST_OK;
    if (head_i.start) begin
      neg_d   = 1'b0;
      acc_d   = '0;
      phase_d = PH_SPACE;
      if (!head_i.alpha_ok) begin
        emit       = 1'b1;
        res_status = ST_BAD_ALPHA;
        phase_d    = PH_IDLE;
      end
    end
    if (!emit) begin
      case (phase_d)
        PH_IDLE: begin
          done = 1'b1;
        end
        PH_SPACE: begin
          if (head_i.space) begin
            done = 1'b1;
          end else begin
            phase_d = PH_SIGNS;
          end
        end
        default: ;
      endcase
      if (!done && phase_d == PH_SIGNS) begin
        if (!head_i.hit) begin
          done = 1'b1;
          if (head_i.minus) begin
            neg_d = !neg_d;
          end else if (!head_i.plus) begin
            emit       = 1'b1;
            res_status = ST_FOREIGN;
            phase_d    = PH_IDLE;
          end
        end else begin
          phase_d = PH_DIGITS;
        end
      end
      if (!done && phase_d == PH_DIGITS) begin
        if (head_i.hit) begin
          acc_d = ValueW'(acc_d * ValueW'(head_i.radix)) + ValueW'(head_i.idx);
        end else begin
          emit      = 1'b1;
          res_value = neg_d ? (ValueW'(0) - acc_d) : acc_d;
          phase_d   = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_value_q  <= res_value;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

  `include "radix_text_to_integer_top_defines.svh"
  `RTTI_ASSERT_NEXT(a_emit_shows, pop_o && emit, out_valid_q)
  `RTTI_ASSERT_NEXT(a_emit_idles, pop_o && emit, phase_q == PH_IDLE)
  `RTTI_ASSERT(a_err_zero, !out_valid_q || out_status_q == ST_OK || out_value_q == '0)

endmodule

>>> sv/radix_text_to_integer_top.sv
// Top level of the radix text to integer converter
//
//  channel   | direction | tdata           | tuser          | other
//  s_axis    | in        | [7:0] character | [0] start_req  | tvalid, tready
//  m_axis    | out       | [63:0] value    | [1:0] status   | tvalid, tready
//  cfg       | in        | cfg_wdata_i     | -              | cfg_we_i, cfg_idx_i
//
//  One character per cycle sustained unless m_axis stalls; the back end does one multiply-add per cycle.
//  The terminating character is queued, and the result is registered in the back end when it is popped.
//  Reset clears the parse state and queue and loads the decimal alphabet.
//  A stalled m_axis fills the two-entry queue; then s_axis_tready drops.
module radix_text_to_integer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rtti_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rtti_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] character
  input  logic [0:0]                   s_axis_tuser,   // [0] start_req
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [63:0]                  m_axis_tdata,   // [63:0] value
  output logic [1:0]                   m_axis_tuser    // [1:0] status
);
  import rtti_pkg::*;

  entry_t  push_entry, head;
  logic    push, q_full, pop, head_valid;
  status_e status;

  rtti_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser[0]),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  rtti_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  rtti_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (m_axis_tdata),
    .out_status_o (status)
  );

  assign m_axis_tuser = status;

endmodule

>>> bench/tb_radix_text_to_integer_top.sv
// Self-checking stream testbench for the radix text to integer converter
`timescale 1ns / 1ps

module tb_radix_text_to_integer_top;
  import rtti_pkg::*;

  localparam int NumSettings     = 16;
  localparam int ItemsPerSetting = 100;
  localparam int SettleCycles    = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       st;
  } text_item_t;

  typedef struct packed {
    logic [63:0] value;
    status_e     status;
  } parsed_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [63:0]         m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  radix_text_to_integer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_item_t text_q[$];
  parsed_t    parsed_q[$];

  logic [63:0] alpha_lo  = AlphaLowRst;
  logic [63:0] alpha_hi  = AlphaHighRst;
  logic [4:0]  alpha_sz  = SizeRst;
  phase_e      cur_phase = PH_IDLE;
  logic        neg_sign  = 1'b0;
  logic [63:0] acc_val   = '0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned src_gap      = 0;
  int unsigned snk_gap      = 0;
  int unsigned hold_left    = 0;
  int          n_errors     = 0;
  int          n_chars      = 0;
  int          n_by_status[3];

  function automatic logic [7:0] sym_at(int k);
    logic [127:0] a;
    a = {alpha_hi, alpha_lo};
    return a[k*8 +: 8];
  endfunction

  function automatic int used_symbols();
    return (alpha_sz > MaxSymbols) ? MaxSymbols : int'(alpha_sz);
  endfunction

  function automatic bit alphabet_valid();
    bit         ok;
    logic [7:0] s;
    ok = (alpha_sz >= 2) && (alpha_sz <= MaxSymbols);
    if (ok) begin
      for (int a = 0; a < alpha_sz; a++) begin
        s = sym_at(a);
        if (s == ChPlus || s == ChMinus || s == ChNul) ok = 1'b0;
        for (int b = a + 1; b < alpha_sz; b++)
          if (sym_at(b) == s) ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic int symbol_index(logic [7:0] ch);
    for (int k = 0; k < used_symbols(); k++)
      if (sym_at(k) == ch) return k;
    return -1;
  endfunction

  function automatic void parse_char(input logic [7:0] ch, input logic st,
                                     output logic hit, output parsed_t res);
    int d;
    hit = 1'b0;
    res.value = '0;
    res.status = ST_OK;
    if (st) begin
      neg_sign = 1'b0;
      acc_val = '0;
      cur_phase = PH_SPACE;
      if (!alphabet_valid()) begin
        hit = 1'b1;
        res.status = ST_BAD_ALPHA;
        cur_phase = PH_IDLE;
        return;
      end
    end
    if (cur_phase == PH_IDLE) return;
    if (cur_phase == PH_SPACE) begin
      if ((ch >= ChWsFirst && ch <= ChWsLast) || ch == ChSpace) return;
      cur_phase = PH_SIGNS;
    end
    d = symbol_index(ch);
    if (cur_phase == PH_SIGNS) begin
      if (d < 0) begin
        if (ch == ChMinus) begin
          neg_sign = !neg_sign;
          return;
        end
        if (ch == ChPlus) return;
        hit = 1'b1;
        res.status = ST_FOREIGN;
        cur_phase = PH_IDLE;
        return;
      end
      cur_phase = PH_DIGITS;
    end
    if (d >= 0) begin
      acc_val = acc_val * 64'(alpha_sz) + 64'(d);
      return;
    end
    hit = 1'b1;
    res.value = neg_sign ? -acc_val : acc_val;
    cur_phase = PH_IDLE;
  endfunction

  task automatic report_mismatch(string what);
    if (n_errors < 50) $display("%0t mismatch: %s", $time, what);
    n_errors++;
  endtask

  // Sender: predict on every accepted transaction, then load the next character
  always @(posedge clk_i) begin : sender
    text_item_t it;
    parsed_t    res;
    logic       hit;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        n_chars++;
        parse_char(s_axis_tdata, s_axis_tuser[0], hit, res);
        if (hit) parsed_q.push_back(res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (text_q.size() != 0 && src_idle_pct != 0 &&
                     $urandom_range(99) < src_idle_pct) begin
          src_gap <= $urandom_range(0, 10);
          s_axis_tvalid <= 1'b0;
        end else if (text_q.size() != 0) begin
          it = text_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= it.ch;
          s_axis_tuser <= it.st;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction against the oldest prediction
  always @(posedge clk_i) begin : receiver
    parsed_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (parsed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h status %0d",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want = parsed_q.pop_front();
          if (m_axis_tdata !== want.value)
            report_mismatch($sformatf("value got %h want %h", m_axis_tdata, want.value));
          if (m_axis_tuser !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, want.status));
          if (want.status <= ST_FOREIGN) n_by_status[want.status]++;
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (snk_gap != 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct) begin
        snk_gap <= $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  task automatic push_text(logic [7:0] ch, logic st);
    text_item_t it;
    it.ch = ch;
    it.st = st;
    text_q.push_back(it);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ALPHA_LOW:  alpha_lo = data;
      CFG_ALPHA_HIGH: alpha_hi = data;
      CFG_ALPHA_SIZE: alpha_sz = data[4:0];
      default: ;
    endcase
  endtask

  // Wait until no character is pending, no result is outstanding and the sink hold is over, then settle
  task automatic drain();
    do @(negedge clk_i);
    while (text_q.size() != 0 || s_axis_tvalid || parsed_q.size() != 0 || hold_left != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_digit();
    if (used_symbols() == 0) return 8'($urandom);
    return sym_at($urandom_range(0, used_symbols() - 1));
  endfunction

  // Queue one number: whitespace, signs, digits, an optional terminator, optional trailing junk
  task automatic queue_number(output int n);
    int         nws, nsg, ndg, r;
    logic       first;
    logic [7:0] ws;
    first = 1'b1;
    n = 0;
    nws = $urandom_range(0, 3);
    nsg = ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 3);
    r = $urandom_range(99);
    ndg = (r < 80) ? $urandom_range(0, 6) : (r < 95) ? $urandom_range(7, 14)
                                                       : $urandom_range(15, 26);
    repeat (nws) begin
      ws = ($urandom_range(5) == 5) ? ChSpace : 8'($urandom_range(ChWsFirst, ChWsLast));
      push_text(ws, first);
      first = 1'b0;
      n++;
    end
    repeat (nsg) begin
      push_text($urandom_range(1) ? ChMinus : ChPlus, first);
      first = 1'b0;
      n++;
    end
    repeat (ndg) begin
      push_text(random_digit(), first);
      first = 1'b0;
      n++;
    end
    if ($urandom_range(99) < 10 && !first) return;
    push_text($urandom_range(99) < 40 ? ChNul : 8'($urandom), first);
    n++;
    repeat ($urandom_range(0, 2)) push_text(8'($urandom), 1'b0);
  endtask

  task automatic queue_noise(output int n);
    n = $urandom_range(1, 5);
    repeat (n) push_text(8'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic random_alphabet(output logic [127:0] a, output logic [4:0] sz);
    bit         clash;
    logic [7:0] b;
    sz = 5'($urandom_range(2, MaxSymbols));
    for (int k = 0; k < MaxSymbols; k++) begin
      do begin
        b = 8'($urandom_range(1, 255));
        clash = (b == ChPlus || b == ChMinus);
        for (int j = 0; j < k; j++)
          if (a[j*8 +: 8] == b) clash = 1'b1;
      end while (clash);
      a[k*8 +: 8] = b;
    end
    for (int k = 0; k < MaxSymbols; k++)
      if (k >= sz && $urandom_range(1)) a[k*8 +: 8] = 8'($urandom);
  endtask

  task automatic pick_setting(input int p, output logic [127:0] a, output logic [4:0] sz);
    random_alphabet(a, sz);
    case (p)
      0: begin
        a = {64'h6665646362613938, 64'h3736353433323130};
        sz = 5'd16;
      end
      1: begin
        a[15:0] = 16'h3130;
        sz = 5'd2;
      end
      2: sz = 5'd0;
      3: sz = 5'd1;
      4: sz = 5'd31;
      5: sz = 5'd17;
      6: begin
        sz = 5'd8;
        a[31:24] = ChPlus;
      end
      7: a[(sz-1)*8 +: 8] = a[7:0];
      8: begin
        a = {64'h4443424139383736, 64'h3534333231300920};
        sz = 5'd16;
      end
      9: begin
        a = {64'h0, {64{1'b1}}};
        sz = 5'd16;
      end
      10: begin
        a = {{64{1'b1}}, 64'h0};
        sz = 5'd2;
      end
      11: a[$urandom_range(0, sz - 1)*8 +: 8] = ChMinus;
      default: ;
    endcase
  endtask

  function automatic int unsigned idle_choice();
    case ($urandom_range(3))
      0: return 0;
      1: return 5;
      2: return 25;
      default: return 50;
    endcase
  endfunction

  initial begin : stimulus
    int           n, budget;
    logic [127:0] a;
    logic [4:0]   sz;
    logic [63:0]  szw;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_text(ChSpace, 1'b1);
    push_text(8'd9, 1'b0);
    push_text(ChMinus, 1'b0);
    push_text("4", 1'b0);
    push_text("2", 1'b0);
    push_text(ChNul, 1'b0);
    push_text(ChPlus, 1'b1);
    push_text(ChMinus, 1'b0);
    push_text(ChPlus, 1'b0);
    push_text("7", 1'b0);
    push_text("x", 1'b0);
    push_text(ChMinus, 1'b1);
    push_text(ChNul, 1'b0);
    push_text(8'h01, 1'b1);
    push_text("5", 1'b1);
    push_text("3", 1'b1);
    push_text(8'hff, 1'b0);
    push_text("7", 1'b0);
    push_text("0", 1'b1);
    push_text(ChNul, 1'b0);
    push_text("1", 1'b0);
    drain();

    for (int p = 0; p < NumSettings; p++) begin
      pick_setting(p, a, sz);
      szw = {$urandom, $urandom};
      szw[4:0] = sz;
      write_reg(CFG_ALPHA_LOW, a[63:0]);
      write_reg(CFG_ALPHA_HIGH, a[127:64]);
      write_reg(CFG_ALPHA_SIZE, szw);
      if (p == 0 || p == NumSettings - 1) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else begin
        src_idle_pct = idle_choice();
        snk_idle_pct = idle_choice();
      end
      budget = 0;
      while (budget < ItemsPerSetting) begin
        if ($urandom_range(99) < 15) queue_noise(n);
        else queue_number(n);
        budget += n;
      end
      if (p == 0) begin
        @(posedge clk_i);
        hold_left <= 150;
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("Run covered %0d characters over %0d alphabet settings plus the reset alphabet.",
             n_chars, NumSettings);
    $display("Results checked: %0d numbers, %0d invalid alphabet, %0d foreign sign character.",
             n_by_status[ST_OK], n_by_status[ST_BAD_ALPHA], n_by_status[ST_FOREIGN]);
    if (n_errors == 0) begin
      $display("radix_text_to_integer_top verification clean");
    end else begin
      $display("radix_text_to_integer_top verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("Run timed out");
    $display("radix_text_to_integer_top verification failed");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/rtti_pkg.sv
sv/rtti_front.sv
sv/rtti_fifo.sv
sv/rtti_back.sv
sv/radix_text_to_integer_top.sv
bench/tb_radix_text_to_integer_top.sv
